@@ sv/adpcm_nibble_decoder_defines.svh @@
// ---------------------------------------------------------------------------
// adpcm_nibble_decoder_defines.svh
// Assertion macros shared by the ADPCM nibble decoder RTL.
// ---------------------------------------------------------------------------
`ifndef ADPCM_NIBBLE_DECODER_DEFINES_SVH
`define ADPCM_NIBBLE_DECODER_DEFINES_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked on every rising clock edge out of reset
`define ADPCM_ASSERT_IMPL(name, clk_sig, rst_n_sig, ante, cons) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |-> (cons)) else $error("ADPCM assertion failed");

// Next-cycle implication, checked on every rising clock edge out of reset
`define ADPCM_ASSERT_NEXT(name, clk_sig, rst_n_sig, ante, cons) \
	name: assert property (@(posedge clk_sig) disable iff (!rst_n_sig) \
		(ante) |=> (cons)) else $error("ADPCM assertion failed");

`else

`define ADPCM_ASSERT_IMPL(name, clk_sig, rst_n_sig, ante, cons)
`define ADPCM_ASSERT_NEXT(name, clk_sig, rst_n_sig, ante, cons)

`endif

`endif

@@ sv/adpcm_pkg.sv @@
// ---------------------------------------------------------------------------
// adpcm_pkg
// Types, limits and tables of the 4-bit ADPCM nibble decoder.
// ---------------------------------------------------------------------------
package adpcm_pkg;

	typedef logic signed [11:0] sample_t;
	typedef logic [5:0]         step_idx_t;
	typedef logic [3:0]         code_t;
	typedef logic [10:0]        step_t;

	localparam int         STEP_COUNT = 49;
	localparam step_idx_t  IDX_MAX    = 6'd48;
	localparam sample_t    PRED_MIN   = 12'sh800;
	localparam sample_t    PRED_MAX   = 12'sh7FF;

	// Step sizes, floor(16 * 1.1^n)
	localparam step_t STEP_ROM [0:STEP_COUNT-1] = '{
		11'd16,   11'd17,   11'd19,   11'd21,   11'd23,   11'd25,   11'd28,
		11'd31,   11'd34,   11'd37,   11'd41,   11'd45,   11'd50,   11'd55,
		11'd60,   11'd66,   11'd73,   11'd80,   11'd88,   11'd97,   11'd107,
		11'd118,  11'd130,  11'd143,  11'd157,  11'd173,  11'd190,  11'd209,
		11'd230,  11'd253,  11'd279,  11'd307,  11'd337,  11'd371,  11'd408,
		11'd449,  11'd494,  11'd544,  11'd598,  11'd658,  11'd724,  11'd796,
		11'd876,  11'd963,  11'd1060, 11'd1166, 11'd1282, 11'd1411, 11'd1552
	};

	// Step index adjustment, selected by the three magnitude bits
	localparam logic signed [4:0] INDEX_MOVE [0:7] = '{
		-5'sd1, -5'sd1, -5'sd1, -5'sd1, 5'sd2, 5'sd4, 5'sd6, 5'sd8
	};

	// Look up the step size; indexes past the table end read the last entry
	function automatic step_t step_size(input step_idx_t idx);
		step_idx_t sel;
		sel = (idx > IDX_MAX) ? IDX_MAX : idx;
		return STEP_ROM[sel];
	endfunction

endpackage

@@ sv/adpcm_nibble_decoder.sv @@
// ---------------------------------------------------------------------------
// adpcm_nibble_decoder
// OKI-style 4-bit ADPCM decoder, one packed byte in, two samples out.
// ---------------------------------------------------------------------------
// Each request carries one byte; the low nibble is decoded first and the high
// nibble second, giving two results per request, the second marked by last.
// The byte is held in an input register and one nibble is decoded per cycle
// into an output register, so the block sustains one result per cycle while
// the output is not stalled. A new request is taken in the cycle its
// predecessor's high nibble moves to the output register, and a finished
// result may wait on a stalled output while the next byte is already held.
// A request's first result passes through the input register and then the
// output register. restart clears the predictor and the step index before
// the low nibble of that byte is decoded.
// ---------------------------------------------------------------------------
`include "adpcm_nibble_decoder_defines.svh"

module adpcm_nibble_decoder (
	input  logic                 clk,
	input  logic                 arst_n,
	// request channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  logic [7:0]           data_byte,
	input  logic                 restart,
	// result channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output adpcm_pkg::sample_t   sample,
	output adpcm_pkg::step_idx_t step_position,
	output logic                 last
);

	// input stage
	logic                 valid_s1;
	logic [7:0]           byte_s1;
	logic                 restart_s1;
	logic                 phase_q;

	// decoder state
	adpcm_pkg::sample_t   predictor_q;
	adpcm_pkg::step_idx_t step_index_q;

	// output register
	logic                 out_valid_q;
	adpcm_pkg::sample_t   sample_q;
	adpcm_pkg::step_idx_t step_position_q;
	logic                 last_q;

	logic                 fire;
	logic                 in_acc;
	logic                 clear_src;
	adpcm_pkg::sample_t   src_pred;
	adpcm_pkg::step_idx_t src_idx;
	adpcm_pkg::code_t     code;
	adpcm_pkg::sample_t   pred_next;
	adpcm_pkg::step_idx_t idx_next;

	// Advance one nibble when the output register is free or being drained
	assign fire     = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall = valid_s1 && !(fire && phase_q);
	assign in_acc   = in_valid && !in_stall;

	// Select the nibble and the starting state, cleared on restart
	assign clear_src = restart_s1 && !phase_q;
	assign src_pred  = clear_src ? '0 : predictor_q;
	assign src_idx   = clear_src ? '0 : step_index_q;
	assign code      = phase_q ? byte_s1[7:4] : byte_s1[3:0];

	adpcm_nibble u_nibble (
		.pred      (src_pred),
		.idx       (src_idx),
		.code      (code),
		.pred_next (pred_next),
		.idx_next  (idx_next)
	);

	// Hold the request byte and track which nibble is next
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			phase_q  <= 1'b0;
		end else if (in_acc) begin
			valid_s1 <= 1'b1;
			phase_q  <= 1'b0;
		end else if (fire) begin
			valid_s1 <= !phase_q;
			phase_q  <= !phase_q;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			byte_s1    <= data_byte;
			restart_s1 <= restart;
		end
	end

	// Update predictor and step index on each decoded nibble
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			predictor_q  <= '0;
			step_index_q <= '0;
		end else if (fire) begin
			predictor_q  <= pred_next;
			step_index_q <= idx_next;
		end
	end

	// Load the result register, drop valid once the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			sample_q        <= pred_next;
			step_position_q <= idx_next;
			last_q          <= phase_q;
		end
	end

	assign out_valid     = out_valid_q;
	assign sample        = sample_q;
	assign step_position = step_position_q;
	assign last          = last_q;

	`ADPCM_ASSERT_IMPL(a_idx_range, clk, arst_n, 1'b1, step_index_q <= adpcm_pkg::IDX_MAX)
	`ADPCM_ASSERT_IMPL(a_accept_only_on_drain, clk, arst_n, in_acc && valid_s1, fire && phase_q)
	`ADPCM_ASSERT_NEXT(a_low_then_high, clk, arst_n, fire && !phase_q, valid_s1 && phase_q)
	`ADPCM_ASSERT_NEXT(a_state_holds, clk, arst_n, !fire, $stable(predictor_q) && $stable(step_index_q))
	`ADPCM_ASSERT_NEXT(a_last_marks_high, clk, arst_n, fire, out_valid_q && last_q == $past(phase_q))

endmodule

@@ sv/adpcm_nibble.sv @@
// ---------------------------------------------------------------------------
// adpcm_nibble
// One ADPCM nibble update: step lookup, difference, saturating predictor
// and clamped step index adaptation.
// ---------------------------------------------------------------------------
module adpcm_nibble (
	input  adpcm_pkg::sample_t   pred,
	input  adpcm_pkg::step_idx_t idx,
	input  adpcm_pkg::code_t     code,
	output adpcm_pkg::sample_t   pred_next,
	output adpcm_pkg::step_idx_t idx_next
);

	adpcm_pkg::step_t   step;
	logic [11:0]        mag;
	logic signed [13:0] mag_s;
	logic signed [13:0] delta;
	logic signed [13:0] sum;
	logic signed [7:0]  idx_sum;

	// Build the difference magnitude from the step and the code bits
	always_comb begin
		step = adpcm_pkg::step_size(idx);
		mag  = 12'(step >> 3)
			+ (code[2] ? 12'(step) : 12'd0)
			+ (code[1] ? 12'(step >> 1) : 12'd0)
			+ (code[0] ? 12'(step >> 2) : 12'd0);
	end

	// Add the signed difference and saturate to the 12-bit range
	always_comb begin
		mag_s = $signed({2'b00, mag});
		delta = code[3] ? -mag_s : mag_s;
		sum   = $signed({{2{pred[11]}}, pred}) + delta;
		if (sum[13:11] == 3'b000 || sum[13:11] == 3'b111) begin
			pred_next = sum[11:0];
		end else if (sum[13]) begin
			pred_next = adpcm_pkg::PRED_MIN;
		end else begin
			pred_next = adpcm_pkg::PRED_MAX;
		end
	end

	// Move the step index and clamp it to the table
	always_comb begin
		idx_sum = $signed({2'b00, idx})
			+ 8'(adpcm_pkg::INDEX_MOVE[code[2:0]]);
		if (idx_sum[7]) begin
			idx_next = '0;
		end else if (idx_sum > $signed({2'b00, adpcm_pkg::IDX_MAX})) begin
			idx_next = adpcm_pkg::IDX_MAX;
		end else begin
			idx_next = idx_sum[5:0];
		end
	end

endmodule
